// File: rtl/core/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and fixed field widths of the percentile rank tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

  // fixed transaction field widths
  localparam int ID_W   = 12;
  localparam int PAGE_W = 10;
  localparam int RANK_W = 17;

  // transaction kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP_QUO,
    ST_WRAP_REM,
    ST_USER_RD,
    ST_USER_DATA,
    ST_DEC_DATA,
    ST_INC_RD,
    ST_INC_DATA,
    ST_WALK,
    ST_DIV_WAIT
  } prt_state_t;

endpackage

// File: rtl/core/prt_ram.sv
// ----------------------------------------------------------------------------
// prt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/prt_divider.sv
// ----------------------------------------------------------------------------
// prt_divider
// Restoring divider, one quotient bit per cycle. The numerator is loaded
// left aligned; after the given number of steps the quotient sits in the
// low bits. Used for the final rank fraction.
// ----------------------------------------------------------------------------
module prt_divider #(
  parameter int NUM_W = 29,
  parameter int REM_W = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num_in,
  input  logic [REM_W-1:0]           den_in,
  input  logic [$clog2(NUM_W+1)-1:0] steps_in,
  output logic                       done,
  output logic [NUM_W-1:0]           quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [REM_W-1:0]  den_r, den_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W:0]    trial;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
    trial  = {1'b0, rem_sh} - {1'b0, den_r};
  end

  // step control
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num_in;
      rem_nxt = '0;
      den_nxt = den_in;
      cnt_nxt = steps_in;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[REM_W]) begin
        rem_nxt = trial[REM_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// File: rtl/core/percentile_rank_tracker_unit.sv
// ----------------------------------------------------------------------------
// percentile_rank_tracker_unit
// Percentile rank histogram: records per-user progress values and answers
// rank fraction queries.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until that transaction is finished, and the block handles one at a time.
// After reset a clearing pass over max(USER_SLOTS, VALUE_LEVELS) addresses
// wipes the known flags and the histogram while busy is high. In a record,
// states ST_WRAP_QUO and ST_WRAP_REM wrap the slot and value by reciprocal
// multiplication with the constant sizes, then a short read-modify-write of
// the histogram follows (no decrement for a user seen for the first time).
// A query gives one result: the histogram RAM read port walks the v lower
// bins one per cycle, v being the user's value, then the bit-serial divider
// forms the fraction one bit per cycle; an unknown or sole user skips the
// walk and the divider. A record gives no result. The result is on
// out_rank_fraction for exactly one cycle, marked by out_strobe, and the
// receiver must take it then: it cannot hold results off.
// ----------------------------------------------------------------------------
module percentile_rank_tracker_unit #(
  parameter int USER_SLOTS    = 4096,
  parameter int VALUE_LEVELS  = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [prt_pkg::ID_W-1:0]    in_user_id,
  input  logic [prt_pkg::PAGE_W-1:0]  in_page_count,
  output logic                        out_strobe,
  output logic [prt_pkg::RANK_W-1:0]  out_rank_fraction
);

  import prt_pkg::*;

  localparam int SLOT_W  = $clog2(USER_SLOTS);
  localparam int VAL_W   = $clog2(VALUE_LEVELS);
  localparam int CNT_W   = $clog2(USER_SLOTS + 1);
  localparam int REM_W   = CNT_W + 1;
  localparam int NUM_W   = CNT_W + FRACTION_BITS;
  localparam int STEP_W  = $clog2(NUM_W + 1);
  localparam int CLR_N   = (USER_SLOTS > VALUE_LEVELS) ? USER_SLOTS : VALUE_LEVELS;
  localparam int CLR_W   = $clog2(CLR_N);
  localparam int QX_W    = (NUM_W > RANK_W) ? NUM_W : RANK_W;
  localparam int SLOT_SHIFT = ID_W + SLOT_W;
  localparam int VAL_SHIFT  = PAGE_W + VAL_W;
  localparam int SPROD_W    = 2 * ID_W + 1;
  localparam int VPROD_W    = 2 * PAGE_W + 1;

  localparam logic [RANK_W-1:0] ONE_FRAC =
    (FRACTION_BITS < RANK_W) ? RANK_W'(64'd1 << FRACTION_BITS) : '0;
  localparam logic [STEP_W-1:0] QUO_STEPS = STEP_W'(NUM_W);
  localparam logic [CLR_W:0]    CLR_SLOTS = (CLR_W + 1)'(USER_SLOTS);
  localparam logic [CLR_W:0]    CLR_VALS  = (CLR_W + 1)'(VALUE_LEVELS);
  localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(CLR_N - 1);

  // rounded-up reciprocals, exact quotients for every field value
  localparam logic [ID_W:0]     SLOT_RECIP = (ID_W + 1)'(
    ((64'd1 << SLOT_SHIFT) + 64'(USER_SLOTS) - 64'd1) / 64'(USER_SLOTS));
  localparam logic [PAGE_W:0]   VAL_RECIP  = (PAGE_W + 1)'(
    ((64'd1 << VAL_SHIFT) + 64'(VALUE_LEVELS) - 64'd1) / 64'(VALUE_LEVELS));
  localparam logic [ID_W-1:0]   SLOT_MOD   = ID_W'(USER_SLOTS);
  localparam logic [PAGE_W-1:0] VAL_MOD    = PAGE_W'(VALUE_LEVELS);

  prt_state_t state_r, state_nxt;

  logic               kind_r, kind_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [ID_W-1:0]    slot_quo_r, slot_quo_nxt;
  logic [PAGE_W-1:0]  page_quo_r, page_quo_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [VAL_W-1:0]   old_r, old_nxt;
  logic [VAL_W-1:0]   walk_r, walk_nxt;
  logic               pend_r, pend_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CLR_W-1:0]   clr_r, clr_nxt;
  logic               strobe_r, strobe_nxt;
  logic [RANK_W-1:0]  frac_r, frac_nxt;

  logic               accept;
  logic               walk_done;
  logic               is_record;

  // index wrapping
  logic [SPROD_W-1:0] slot_prod;
  logic [VPROD_W-1:0] page_prod;
  logic [ID_W-1:0]    slot_low;
  logic [PAGE_W-1:0]  page_low;

  // divider interface
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [REM_W-1:0]   div_den;
  logic [STEP_W-1:0]  div_steps;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [QX_W-1:0]    quo_x;

  // ram ports
  logic               known_we, known_wd, known_q;
  logic [SLOT_W-1:0]  known_waddr;
  logic               prog_we;
  logic [VAL_W-1:0]   prog_q;
  logic               hist_we;
  logic [VAL_W-1:0]   hist_waddr, hist_raddr;
  logic [CNT_W-1:0]   hist_wd, hist_q;

  assign accept    = start && (state_r == ST_IDLE);
  assign walk_done = (walk_r == val_r) && !pend_r;
  assign is_record = (kind_r == KIND_RECORD);
  assign quo_x     = QX_W'(div_quo);

  // slot and value wrap: quotient by reciprocal, then remainder
  assign slot_prod = SPROD_W'(id_r) * SPROD_W'(SLOT_RECIP);
  assign page_prod = VPROD_W'(page_r) * VPROD_W'(VAL_RECIP);
  assign slot_low  = id_r - slot_quo_r * SLOT_MOD;
  assign page_low  = page_r - page_quo_r * VAL_MOD;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_WRAP_QUO;
        end
      end
      ST_WRAP_QUO: begin
        state_nxt = ST_WRAP_REM;
      end
      ST_WRAP_REM: begin
        state_nxt = ST_USER_RD;
      end
      ST_USER_RD: begin
        state_nxt = ST_USER_DATA;
      end
      ST_USER_DATA: begin
        priority if (is_record) begin
          state_nxt = known_q ? ST_DEC_DATA : ST_INC_RD;
        end else if (!known_q || total_r <= CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_DEC_DATA: begin
        state_nxt = ST_INC_RD;
      end
      ST_INC_RD: begin
        state_nxt = ST_INC_DATA;
      end
      ST_INC_DATA: begin
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // ram and divider controls
  always_comb begin
    div_start   = 1'b0;
    div_num     = NUM_W'(acc_r) << (NUM_W - CNT_W);
    div_den     = REM_W'(total_r - CNT_W'(1));
    div_steps   = QUO_STEPS;
    known_we    = 1'b0;
    known_wd    = 1'b0;
    known_waddr = slot_r;
    prog_we     = 1'b0;
    hist_we     = 1'b0;
    hist_waddr  = old_r;
    hist_wd     = '0;
    hist_raddr  = walk_r;
    unique case (state_r)
      ST_CLEAR: begin
        known_waddr = clr_r[SLOT_W-1:0];
        known_we    = ({1'b0, clr_r} < CLR_SLOTS);
        hist_waddr  = clr_r[VAL_W-1:0];
        hist_we     = ({1'b0, clr_r} < CLR_VALS);
      end
      ST_USER_DATA: begin
        if (is_record) begin
          known_we   = 1'b1;
          known_wd   = 1'b1;
          prog_we    = 1'b1;
          hist_raddr = prog_q;
        end
      end
      ST_DEC_DATA: begin
        hist_we    = (hist_q != '0);
        hist_waddr = old_r;
        hist_wd    = hist_q - CNT_W'(1);
      end
      ST_INC_RD: begin
        hist_raddr = val_r;
      end
      ST_INC_DATA: begin
        hist_we    = 1'b1;
        hist_waddr = val_r;
        hist_wd    = hist_q + CNT_W'(1);
      end
      ST_WALK: begin
        div_start = walk_done;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    kind_nxt     = kind_r;
    page_nxt     = page_r;
    id_nxt       = id_r;
    slot_quo_nxt = slot_quo_r;
    page_quo_nxt = page_quo_r;
    slot_nxt     = slot_r;
    val_nxt      = val_r;
    old_nxt      = old_r;
    walk_nxt     = walk_r;
    pend_nxt     = pend_r;
    acc_nxt      = acc_r;
    total_nxt    = total_r;
    clr_nxt      = clr_r;
    strobe_nxt   = 1'b0;
    frac_nxt     = frac_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + CLR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          page_nxt = in_page_count;
          id_nxt   = in_user_id;
        end
      end
      ST_WRAP_QUO: begin
        slot_quo_nxt = ID_W'(slot_prod >> SLOT_SHIFT);
        page_quo_nxt = PAGE_W'(page_prod >> VAL_SHIFT);
      end
      ST_WRAP_REM: begin
        slot_nxt = SLOT_W'(slot_low);
        val_nxt  = VAL_W'(page_low);
      end
      ST_USER_DATA: begin
        priority if (is_record) begin
          old_nxt = prog_q;
          if (!known_q) begin
            total_nxt = total_r + CNT_W'(1);
          end
        end else if (!known_q) begin
          strobe_nxt = 1'b1;
          frac_nxt   = '0;
        end else if (total_r <= CNT_W'(1)) begin
          strobe_nxt = 1'b1;
          frac_nxt   = ONE_FRAC;
        end else begin
          val_nxt  = prog_q;
          walk_nxt = '0;
          pend_nxt = 1'b0;
          acc_nxt  = '0;
        end
      end
      ST_WALK: begin
        if (pend_r) begin
          acc_nxt = acc_r + hist_q;
        end
        if (walk_r != val_r) begin
          walk_nxt = walk_r + VAL_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          strobe_nxt = 1'b1;
          frac_nxt   = quo_x[RANK_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      total_r  <= '0;
      strobe_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      total_r  <= total_nxt;
      strobe_r <= strobe_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    page_r     <= page_nxt;
    id_r       <= id_nxt;
    slot_quo_r <= slot_quo_nxt;
    page_quo_r <= page_quo_nxt;
    slot_r     <= slot_nxt;
    val_r      <= val_nxt;
    old_r      <= old_nxt;
    walk_r     <= walk_nxt;
    acc_r      <= acc_nxt;
    frac_r     <= frac_nxt;
  end

  // bit-serial divider
  prt_divider #(
    .NUM_W (NUM_W),
    .REM_W (REM_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num_in   (div_num),
    .den_in   (div_den),
    .steps_in (div_steps),
    .done     (div_done),
    .quo      (div_quo)
  );

  // known flag per user slot
  prt_ram #(
    .WIDTH (1),
    .DEPTH (USER_SLOTS)
  ) u_known_ram (
    .clk   (clk),
    .we    (known_we),
    .waddr (known_waddr),
    .wdata (known_wd),
    .raddr (slot_r),
    .rdata (known_q)
  );

  // progress value per user slot
  prt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (USER_SLOTS)
  ) u_progress_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (slot_r),
    .wdata (val_r),
    .raddr (slot_r),
    .rdata (prog_q)
  );

  // users per value histogram
  prt_ram #(
    .WIDTH (CNT_W),
    .DEPTH (VALUE_LEVELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wd),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = strobe_r;
  assign out_rank_fraction = frac_r;

endmodule
